// ===== hdl/pua_pkg.sv =====
// ---------------------------------------------------------------------------
// pua_pkg: shared types and constants of the polar unwrap address generator
// Beat layouts for pixel positions and source addresses, the configuration
// bundle, the register indexes and the fixed field widths.
// ---------------------------------------------------------------------------
package pua_pkg;

  // field widths
  localparam int unsigned COL_W   = 16;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned COORD_W = 13;
  localparam int unsigned INV_W   = 21;
  localparam int unsigned STEP_W  = 32;

  // phase is one turn in Q0.32, top two bits pick the quadrant
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned QUAD_POS_W = 30;

  // radius in Q19.16
  localparam int unsigned R_W = ROW_W + INV_W;

  // centre = width/2 sits at 15 + frac bits, products at 16 + frac bits
  localparam int unsigned CENTRE_BASE_SHIFT = 15;
  localparam int unsigned PROD_BASE_SHIFT   = 16;

  // apb port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // register indexes, one word apart
  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_INV_SCALE     = 2'd2,
    REG_ANGLE_STEP    = 2'd3
  } reg_idx_e;

  // input beat
  typedef struct packed {
    logic [COL_W-1:0] dst_col;
    logic [ROW_W-1:0] dst_row;
  } pixel_in_t;

  // result beat
  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               out_of_range;
  } pixel_out_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [COORD_W-1:0] source_width;
    logic [COORD_W-1:0] source_height;
    logic [INV_W-1:0]   inv_scale_q16;
    logic [STEP_W-1:0]  angle_step_q32;
  } cfg_t;

endpackage

// ===== hdl/pua_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// pua_cfg_regs: configuration register file
// APB-style slave holding source geometry, inverse scale and angle step.
// Zero wait states, registers readable at their byte address.
// ---------------------------------------------------------------------------
module pua_cfg_regs import pua_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  localparam logic [COORD_W-1:0] RST_SOURCE_WIDTH  = COORD_W'(1024);
  localparam logic [COORD_W-1:0] RST_SOURCE_HEIGHT = COORD_W'(1024);
  localparam logic [INV_W-1:0]   RST_INV_SCALE     = INV_W'(65536);
  localparam logic [STEP_W-1:0]  RST_ANGLE_STEP    = STEP_W'(1335088);

  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width   <= RST_SOURCE_WIDTH;
      cfg_q.source_height  <= RST_SOURCE_HEIGHT;
      cfg_q.inv_scale_q16  <= RST_INV_SCALE;
      cfg_q.angle_step_q32 <= RST_ANGLE_STEP;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SOURCE_WIDTH:  cfg_q.source_width   <= pwdata[COORD_W-1:0];
        REG_SOURCE_HEIGHT: cfg_q.source_height  <= pwdata[COORD_W-1:0];
        REG_INV_SCALE:     cfg_q.inv_scale_q16  <= pwdata[INV_W-1:0];
        REG_ANGLE_STEP:    cfg_q.angle_step_q32 <= pwdata[STEP_W-1:0];
        default:           cfg_q                <= cfg_q;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_sel)
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(cfg_q.source_width);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(cfg_q.source_height);
      REG_INV_SCALE:     prdata = APB_DATA_W'(cfg_q.inv_scale_q16);
      REG_ANGLE_STEP:    prdata = APB_DATA_W'(cfg_q.angle_step_q32);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/pua_sine_rom.sv =====
// ---------------------------------------------------------------------------
// pua_sine_rom: dual-port quarter-wave sine rom
// 2^TABLE_BITS+1 entries in Q1.FRAC_BITS, built at elaboration from a Q30
// Taylor series. Two registered read ports for sine and cosine.
// ---------------------------------------------------------------------------
module pua_sine_rom import pua_pkg::*; #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned FRAC_BITS  = 15
) (
  input  logic                clk_i,
  input  logic [TABLE_BITS:0] addr_a_i,
  input  logic [TABLE_BITS:0] addr_b_i,
  output logic [FRAC_BITS:0]  data_a_o,
  output logic [FRAC_BITS:0]  data_b_o
);

  localparam int unsigned TABLE_LEN   = (1 << TABLE_BITS) + 1;
  localparam int unsigned TABLE_STEPS = 1 << TABLE_BITS;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  typedef logic [FRAC_BITS:0] rom_t [TABLE_LEN];

  // one table entry: sin(pi/2 * k / steps) rounded to frac bits, capped at one
  function automatic logic [FRAC_BITS:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    logic [63:0]        e;
    int unsigned        n;
    x    = (64'(k) * HALF_PI_Q30 + 64'(TABLE_STEPS >> 1)) >> TABLE_BITS;
    term = x;
    sum  = $signed(x);
    for (n = 0; n < TAYLOR_TERMS; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TAYLOR_DIV[n]);
      if (n[0] == 1'b0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    s = $unsigned(sum);
    e = ((s << FRAC_BITS) + (64'd1 << 29)) >> 30;
    if (e > (64'd1 << FRAC_BITS)) begin
      e = 64'd1 << FRAC_BITS;
    end
    return e[FRAC_BITS:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    int unsigned k;
    for (k = 0; k < TABLE_LEN; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // registered reads
  always_ff @(posedge clk_i) begin
    data_a_o <= SINE_ROM[addr_a_i];
    data_b_o <= SINE_ROM[addr_b_i];
  end

endmodule

// ===== hdl/pua_axis.sv =====
// ---------------------------------------------------------------------------
// pua_axis: one source coordinate, centre minus radius times sine
// Three stages: radius by magnitude product, signed add against the centre,
// truncation with clamp into the frame and the out-of-frame flag.
// ---------------------------------------------------------------------------
module pua_axis import pua_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic               clk_i,
  input  logic [R_W-1:0]     r_i,
  input  logic [FRAC_BITS:0] mag_i,
  input  logic               neg_i,
  input  logic [COORD_W-1:0] width_i,
  input  logic [COORD_W-1:0] bound_i,
  output logic [COORD_W-1:0] coord_o,
  output logic               flag_o
);

  localparam int unsigned MAG_W  = FRAC_BITS + 1;
  localparam int unsigned P_W    = R_W + MAG_W;
  localparam int unsigned S_W    = P_W + 2;
  localparam int unsigned SHIFT  = PROD_BASE_SHIFT + FRAC_BITS;
  localparam int unsigned CSHIFT = CENTRE_BASE_SHIFT + FRAC_BITS;
  localparam int unsigned V_W    = S_W - 1 - SHIFT;
  // minus one whole pixel in the sum format
  localparam logic [S_W-1:0] NEG_LIMIT = ~(S_W'(1) << SHIFT) + S_W'(1);

  logic [P_W-1:0]     prod_q;
  logic               neg_q;
  logic [S_W-1:0]     centre_ext;
  logic [S_W-1:0]     prod_ext;
  logic [S_W-1:0]     sum_d, sum_q;
  logic [COORD_W-1:0] bound_m1;
  logic [V_W-1:0]     whole;
  logic               over;
  logic [COORD_W-1:0] coord_d, coord_q;
  logic               flag_d, flag_q;

  // stage a: exact product r * |sin|
  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(r_i) * P_W'(mag_i);
    neg_q  <= neg_i;
  end

  // stage b: centre plus or minus product, signed
  assign centre_ext = S_W'(width_i) << CSHIFT;
  assign prod_ext   = S_W'(prod_q);
  assign sum_d      = neg_q ? (centre_ext + prod_ext) : (centre_ext - prod_ext);

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // stage c: truncate toward zero and clamp, a zero bound acts as one
  assign bound_m1 = (bound_i == '0) ? '0 : (bound_i - COORD_W'(1));
  assign whole    = sum_q[S_W-2:SHIFT];
  assign over     = whole > V_W'(bound_m1);

  always_comb begin
    if (sum_q[S_W-1]) begin
      coord_d = '0;
      flag_d  = $signed(sum_q) <= $signed(NEG_LIMIT);
    end else begin
      coord_d = over ? bound_m1 : whole[COORD_W-1:0];
      flag_d  = over;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    flag_q  <= flag_d;
  end

  assign coord_o = coord_q;
  assign flag_o  = flag_q;

endmodule

// ===== hdl/polar_unwrap_address_generator.sv =====
// ---------------------------------------------------------------------------
// polar_unwrap_address_generator: panorama to circular-image source address
// Pipeline: an accepted item passes the input, multiply, rom, product, add
//   and clamp registers before its result strobe.
// Throughput: one item per cycle, busy stays low; the six-stage pipeline and
//   the two rom read ports are the limit.
// Reset: clears the valid pipeline and loads the register defaults; the sine
//   rom is constant, so no clearing pass.
// ---------------------------------------------------------------------------
module polar_unwrap_address_generator import pua_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned SINE_FRAC_BITS  = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pixel_in_t             item_i,
  output logic                  result_valid_o,
  output pixel_out_t            result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = SINE_TABLE_BITS + 1;
  localparam int unsigned MAG_W = SINE_FRAC_BITS + 1;
  localparam logic [IDX_W-1:0] TABLE_STEPS = IDX_W'(1) << SINE_TABLE_BITS;
  localparam logic [QUAD_POS_W:0] ROUND_HALF =
    (QUAD_POS_W + 1)'(1) << (QUAD_POS_W - 1 - SINE_TABLE_BITS);

  cfg_t                  cfg;
  logic                  accept;
  logic                  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  pixel_in_t             item_q;
  logic [R_W-1:0]        r1_q, r2_q;
  logic [PHASE_W-1:0]    phase1_q;
  logic [1:0]            quad_sin, quad_cos;
  logic [QUAD_POS_W:0]   round_sum;
  logic [IDX_W-1:0]      idx, idx_mirror, idx_sin, idx_cos;
  logic                  neg_x_q, neg_y_q;
  logic [MAG_W-1:0]      mag_x, mag_y;
  logic [COORD_W-1:0]    src_x, src_y;
  logic                  flag_x, flag_y;

  // configuration registers
  pua_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // no back pressure: a beat is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 0: input beat register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // stage 1: radius and wrapped phase
  always_ff @(posedge clk_i) begin
    r1_q     <= R_W'(item_q.dst_row) * R_W'(cfg.inv_scale_q16);
    phase1_q <= PHASE_W'(item_q.dst_col) * cfg.angle_step_q32;
  end

  // stage 2: quadrant, rounded table index, mirror; cosine is one quadrant on
  assign quad_sin   = phase1_q[PHASE_W-1:QUAD_POS_W];
  assign quad_cos   = quad_sin + 2'd1;
  assign round_sum  = {1'b0, phase1_q[QUAD_POS_W-1:0]} + ROUND_HALF;
  assign idx        = round_sum[QUAD_POS_W -: IDX_W];
  assign idx_mirror = TABLE_STEPS - idx;
  assign idx_sin    = quad_sin[0] ? idx_mirror : idx;
  assign idx_cos    = quad_cos[0] ? idx_mirror : idx;

  pua_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS),
    .FRAC_BITS  (SINE_FRAC_BITS)
  ) u_rom (
    .clk_i    (clk_i),
    .addr_a_i (idx_sin),
    .addr_b_i (idx_cos),
    .data_a_o (mag_x),
    .data_b_o (mag_y)
  );

  always_ff @(posedge clk_i) begin
    r2_q    <= r1_q;
    neg_x_q <= quad_sin[1];
    neg_y_q <= quad_cos[1];
  end

  // stages 3 to 5: one axis unit per coordinate
  pua_axis #(
    .FRAC_BITS (SINE_FRAC_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .r_i     (r2_q),
    .mag_i   (mag_x),
    .neg_i   (neg_x_q),
    .width_i (cfg.source_width),
    .bound_i (cfg.source_width),
    .coord_o (src_x),
    .flag_o  (flag_x)
  );

  pua_axis #(
    .FRAC_BITS (SINE_FRAC_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .r_i     (r2_q),
    .mag_i   (mag_y),
    .neg_i   (neg_y_q),
    .width_i (cfg.source_width),
    .bound_i (cfg.source_height),
    .coord_o (src_y),
    .flag_o  (flag_y)
  );

  // result beat
  assign result_valid_o        = v5_q;
  assign result_o.src_x        = src_x;
  assign result_o.src_y        = src_y;
  assign result_o.out_of_range = flag_x | flag_y;

  // every accepted beat comes out as a result strobe
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 result_valid_o)
    else $error("accepted beat did not produce a result");

  // no result without an accepted beat
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##6 !result_valid_o)
    else $error("result strobe without an accepted beat");

  // sine and cosine lookups come from mirrored indexes, never both zero
  a_sin_cos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (mag_x != '0 || mag_y != '0))
    else $error("sine and cosine magnitudes both zero");

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the polar unwrap address generator
// A queue of panorama pixel positions feeds a bursty command driver. Each
// accepted beat is run through a local fixed-point model of the unwrap (own
// quarter-wave sine table, radius, angle, truncation and clamping), and the
// monitor checks every result strobe against the oldest expected address.
// Register settings change only between phases, once the pipeline is empty.
// ---------------------------------------------------------------------------
module tb;
  import pua_pkg::*;

  // model constants, matching the block defaults
  localparam int unsigned TBL_BITS    = 10;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned TBL_STEPS   = 1 << TBL_BITS;
  localparam int unsigned TBL_LEN     = TBL_STEPS + 1;
  localparam int unsigned CENTRE_SHIFT = CENTRE_BASE_SHIFT + FRAC_BITS;
  localparam int unsigned PROD_SHIFT  = PROD_BASE_SHIFT + FRAC_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned ROW_MAX     = (1 << ROW_W) - 1;

  localparam int unsigned LAT_PAD     = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  pixel_in_t             pix_in  = '0;
  logic                  result_valid_o;
  pixel_out_t            result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // model state
  longint unsigned qsine [0:TBL_LEN-1];
  cfg_t            cur_cfg;
  pixel_in_t       pixel_q [$];
  pixel_out_t      exp_addr_q [$];
  pixel_out_t      exp_addr;
  int unsigned     err_cnt = 0;
  int unsigned     gap_left = 0;
  int unsigned     burst_left = 0;
  int unsigned     cyc;

  polar_unwrap_address_generator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (pix_in),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // sin(x) in q30 for 0 <= x <= pi/2, truncating taylor series
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned term;
    longint          sum;
    int unsigned     n;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : $unsigned(sum);
  endfunction

  // quarter-wave table, rounded to frac bits and capped at one
  task automatic build_sine_table();
    longint unsigned x, s, e;
    int unsigned     k;
    for (k = 0; k < TBL_LEN; k++) begin
      x = (64'(k) * HALF_PI_Q30 + 64'(TBL_STEPS >> 1)) / 64'(TBL_STEPS);
      s = sine_q30(x);
      e = ((s << FRAC_BITS) + (64'd1 << 29)) >> 30;
      if (e > (64'd1 << FRAC_BITS)) e = 64'd1 << FRAC_BITS;
      qsine[k] = e;
    end
  endtask

  // sine magnitude of a q0.32 phase, sign returned separately
  function automatic longint unsigned sine_mag(logic [PHASE_W-1:0] phase, output bit neg);
    logic [31:0] idx;
    idx = (32'(phase[QUAD_POS_W-1:0]) + (32'd1 << (29 - TBL_BITS))) >> (30 - TBL_BITS);
    if (idx > TBL_STEPS) idx = TBL_STEPS;
    if (phase[30]) idx = TBL_STEPS - idx;
    neg = phase[31];
    return qsine[idx];
  endfunction

  // centre - r*sin(phase), truncated and clamped; msb is the clamp flag
  function automatic logic [COORD_W:0] axis_addr(longint unsigned centre, longint unsigned r,
                                                 logic [PHASE_W-1:0] phase,
                                                 logic [COORD_W-1:0] bound);
    bit              neg;
    longint unsigned prod, v, lim;
    logic            flag;
    prod = r * sine_mag(phase, neg);
    lim  = (bound == '0) ? 64'd1 : 64'(bound);
    flag = 1'b0;
    if (neg) begin
      v = (centre + prod) >> PROD_SHIFT;
    end else if (centre >= prod) begin
      v = (centre - prod) >> PROD_SHIFT;
    end else begin
      // a value in (-1, 0) truncates to zero and stays in range
      flag = ((prod - centre) >> PROD_SHIFT) != 0;
      return {flag, {COORD_W{1'b0}}};
    end
    if (v > lim - 1) begin
      flag = 1'b1;
      v    = lim - 1;
    end
    return {flag, v[COORD_W-1:0]};
  endfunction

  // source address of one panorama pixel under a register setting
  function automatic pixel_out_t predict_src_addr(pixel_in_t p, cfg_t c);
    longint unsigned    r, centre;
    logic [PHASE_W-1:0] phase;
    logic [COORD_W:0]   ax, ay;
    pixel_out_t         o;
    r      = 64'(p.dst_row) * 64'(c.inv_scale_q16);
    phase  = 32'(64'(p.dst_col) * 64'(c.angle_step_q32));
    centre = 64'(c.source_width) << CENTRE_SHIFT;
    ax = axis_addr(centre, r, phase, c.source_width);
    ay = axis_addr(centre, r, phase + 32'h4000_0000, c.source_height);
    o.src_x        = ax[COORD_W-1:0];
    o.src_y        = ay[COORD_W-1:0];
    o.out_of_range = ax[COORD_W] | ay[COORD_W];
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  // command driver: bursts with random gaps, holds a beat while busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      pix_in     <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (start && !busy) exp_addr_q.push_back(predict_src_addr(pix_in, cur_cfg));
      if (start && busy) begin
        // keep the beat on the port until taken
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        pix_in <= pixel_q.pop_front();
        start  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: one strobe per beat, compared field by field
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (exp_addr_q.size() == 0) begin
        report_mismatch($sformatf("result x=%0d y=%0d oor=%0b with nothing pending",
                                  result_o.src_x, result_o.src_y, result_o.out_of_range));
      end else begin
        exp_addr = exp_addr_q.pop_front();
        if (result_o.src_x !== exp_addr.src_x)
          report_mismatch($sformatf("src_x got %0d want %0d", result_o.src_x, exp_addr.src_x));
        if (result_o.src_y !== exp_addr.src_y)
          report_mismatch($sformatf("src_y got %0d want %0d", result_o.src_y, exp_addr.src_y));
        if (result_o.out_of_range !== exp_addr.out_of_range)
          report_mismatch($sformatf("out_of_range got %0b want %0b",
                                    result_o.out_of_range, exp_addr.out_of_range));
      end
    end
  end

  // apb write: setup then access, register taken when pready is high
  task automatic write_reg(reg_idx_e idx, logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  cur_cfg.source_width   = val[COORD_W-1:0];
      REG_SOURCE_HEIGHT: cur_cfg.source_height  = val[COORD_W-1:0];
      REG_INV_SCALE:     cur_cfg.inv_scale_q16  = val[INV_W-1:0];
      REG_ANGLE_STEP:    cur_cfg.angle_step_q32 = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] w, logic [31:0] h, logic [31:0] inv,
                            logic [31:0] step);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_INV_SCALE, inv);
    write_reg(REG_ANGLE_STEP, step);
    @(negedge clk_i);
  endtask

  task automatic add_pixel(int unsigned col, int unsigned row);
    pixel_in_t p;
    p.dst_col = col[COL_W-1:0];
    p.dst_row = row[ROW_W-1:0];
    pixel_q.push_back(p);
  endtask

  // sender holds off until the pipeline has drained
  task automatic wait_idle();
    do @(negedge clk_i); while (pixel_q.size() != 0 || start || exp_addr_q.size() != 0);
    repeat (LAT_PAD) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random register setting, weighted toward useful geometries
  task automatic pick_random_config();
    logic [31:0] w, h, inv, step;
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8191);
    h = ($urandom_range(0, 3) == 0) ? w : $urandom_range(1, 8191);
    case ($urandom_range(0, 3))
      0: inv = $urandom_range(1, 1048576);
      1: inv = (32'd1 << $urandom_range(10, 20)) | $urandom_range(0, 1023);
      2: inv = $urandom_range(0, (1 << INV_W) - 1);
      default: inv = 65536 + $urandom_range(0, 512) - 256;
    endcase
    step = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1 << 20);
    set_config(w, h, inv, step);
  endtask

  // random pixels: half over the full row range, half up to a row cap near the frame edge
  task automatic add_random_pixels(int unsigned n);
    longint unsigned row_cap;
    int unsigned     i;
    if (cur_cfg.inv_scale_q16 == 0) row_cap = ROW_MAX;
    else row_cap = ((64'(cur_cfg.source_width) + 8) << 16) / 64'(cur_cfg.inv_scale_q16);
    if (row_cap > ROW_MAX) row_cap = ROW_MAX;
    for (i = 0; i < n; i++) begin
      if (i % 2 == 1) add_pixel($urandom_range(0, 65535), $urandom_range(0, ROW_MAX));
      else add_pixel($urandom_range(0, 65535), $urandom_range(0, int'(row_cap)));
    end
  endtask

  // run limit
  initial begin
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("tb: FAIL");
    $finish;
  end

  // stimulus phases
  initial begin
    int unsigned ph;
    build_sine_table();
    cur_cfg.source_width   = 1024;
    cur_cfg.source_height  = 1024;
    cur_cfg.inv_scale_q16  = 65536;
    cur_cfg.angle_step_q32 = 1335088;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting, field extremes
    add_pixel(0, 0);
    add_pixel(65535, ROW_MAX);
    add_pixel(1608, 512);
    add_pixel(804, 300);
    wait_idle();

    // quarter turns at col 64, slightly over unit radius
    set_config(1024, 1024, 65537, 32'd1 << 24);
    add_pixel(0, 512);    // just below zero row, truncates to zero unflagged
    add_pixel(0, 513);    // negative row, clamped and flagged
    add_pixel(64, 512);   // negative column side
    add_pixel(128, 512);  // past the far edge, clamped to bound-1
    add_pixel(192, 512);
    add_pixel(32, 300);
    add_pixel(96, 300);
    add_pixel(160, 300);
    add_pixel(224, 300);
    add_pixel(0, ROW_MAX);
    wait_idle();

    // largest width, height and angle step register values
    set_config(8191, 8191, 1048576, 32'hFFFF_FFFF);
    add_pixel(0, 0);
    add_pixel(1, 1);
    add_pixel(65535, ROW_MAX);
    add_pixel(16'h5555, 14'h2AAA);
    add_pixel(16'hAAAA, 14'h1555);
    wait_idle();

    // zero width and height, zero step
    set_config(0, 0, 65536, 0);
    add_pixel(0, 0);
    add_pixel(0, 5);
    add_pixel(100, 5);
    wait_idle();

    // zero scale with odd width gives a half-pixel centre
    set_config(8191, 1, 0, 32'd1 << 30);
    add_pixel(0, ROW_MAX);
    add_pixel(3, 100);
    wait_idle();

    // smallest legal values
    set_config(2, 1, 1, 0);
    add_pixel(0, 0);
    add_pixel(65535, ROW_MAX);
    wait_idle();

    // random settings and pixels
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      pick_random_config();
      add_random_pixels(PHASE_ITEMS);
      wait_idle();
    end

    if (exp_addr_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", exp_addr_q.size()));
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
